[sv/cbsd_pkg.sv]
// Shared types and constants for the command byte stream decoder.
// No dependencies; imported by the top level and by cbsd_ctrl.
package cbsd_pkg;

    localparam int HISTORY_DEPTH = 256;
    localparam int HEAD_DEPTH    = 288;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int HEAD_AW       = $clog2(HEAD_DEPTH);
    // operand + run index spans 0..286
    localparam int POS_W         = 9;

    localparam logic [7:0]  END_BYTE  = 8'hFF;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        CMD_LIT  = 3'd0,
        CMD_REP  = 3'd1,
        CMD_ALT  = 3'd2,
        CMD_INC  = 3'd3,
        CMD_ABS  = 3'd4,
        CMD_BAD  = 3'd5,
        CMD_REL  = 3'd6,
        CMD_ABS2 = 3'd7
    } cmd_t;

    // One result beat from the sequencer to the output register
    typedef struct packed {
        logic        valid;
        logic [7:0]  data;
        logic        last;
        logic        bad;
        logic        done;
        logic [15:0] total;
    } cbsd_beat_t;

    // Memory port requests from the sequencer
    typedef struct packed {
        logic               hist_we;
        logic [HIST_AW-1:0] hist_waddr;
        logic               hist_re;
        logic [HIST_AW-1:0] hist_raddr;
        logic               head_we;
        logic [HEAD_AW-1:0] head_waddr;
        logic               head_re;
        logic [HEAD_AW-1:0] head_raddr;
        logic [7:0]         wdata;
    } cbsd_memreq_t;

endpackage

[sv/command_byte_stream_decoder_unit.sv]
// Top level of the command byte stream decoder: sequencer, history and head
// RAMs, output register. Depends on cbsd_pkg, cbsd_ram and cbsd_ctrl.
//
// Usage: compressed bytes enter on the s_axis beat channel, one byte per beat.
// Decoded results leave on m_axis, one byte per beat. tlast marks the last
// result caused by one input byte; tuser flags a skipped bad command (bit 0)
// and the end-of-stream beat (bit 1), which carries the saturating total in
// tdata[23:8] and a zero byte.
// Timing: a literal, bad-command or end byte shows up in the cycle after it is
// taken. A repeat, alternate or count-up run starts once its run phase is
// registered after its last operand beat and gives one byte per cycle while
// the output is free; a copy run issues each RAM read into the registered read
// data before its byte, then gives one byte per free output cycle, overlapping
// reads and writes through a forwarding path. Throughput: one input beat per
// cycle for command, operand and literal bytes while the output is free; the input waits during a run.
// Reset: clears the parser and counters and all history valid bits at once,
// so the ring reads as zero; no sweep cycles. The head store needs no reset.
// Stall: while m_axis_tready is low the output register holds its beat and
// the sequencer and input channel wait; a copy run may still issue one read.
module command_byte_stream_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] total_bytes
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser    // [0] bad_command, [1] stream_done
);
    import cbsd_pkg::*;

    cbsd_beat_t   beat;
    cbsd_memreq_t mreq;
    logic [7:0]   hist_rdata;
    logic [7:0]   head_rdata;
    logic         out_free;

    logic         m_valid_reg;
    logic [7:0]   m_data_reg;
    logic [15:0]  m_total_reg;
    logic         m_last_reg;
    logic         m_bad_reg;
    logic         m_done_reg;

    assign out_free = !m_valid_reg || m_axis_tready;

    cbsd_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .out_free   (out_free),
        .beat       (beat),
        .mreq       (mreq),
        .hist_rdata (hist_rdata),
        .head_rdata (head_rdata)
    );

    // History ring
    cbsd_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (mreq.hist_we),
        .waddr (mreq.hist_waddr),
        .wdata (mreq.wdata),
        .re    (mreq.hist_re),
        .raddr (mreq.hist_raddr),
        .rdata (hist_rdata)
    );

    // Head store: first output bytes of the current stream
    cbsd_ram #(
        .WIDTH (8),
        .DEPTH (HEAD_DEPTH)
    ) u_head_ram (
        .aclk  (aclk),
        .we    (mreq.head_we),
        .waddr (mreq.head_waddr),
        .wdata (mreq.wdata),
        .re    (mreq.head_re),
        .raddr (mreq.head_raddr),
        .rdata (head_rdata)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (beat.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (beat.valid) begin
            m_data_reg  <= beat.data;
            m_total_reg <= beat.total;
            m_last_reg  <= beat.last;
            m_bad_reg   <= beat.bad;
            m_done_reg  <= beat.done;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_total_reg, m_data_reg};
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = {m_done_reg, m_bad_reg};

endmodule

[sv/cbsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies. Read during write to the same address returns old data.
module cbsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/cbsd_ctrl.sv]
// Command parser and run sequencer: decodes command bytes, generates output
// bytes, drives the history and head RAMs. Depends on cbsd_pkg.
module cbsd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    input  logic                  out_free,
    output cbsd_pkg::cbsd_beat_t  beat,
    output cbsd_pkg::cbsd_memreq_t mreq,
    input  logic [7:0]            hist_rdata,
    input  logic [7:0]            head_rdata
);
    import cbsd_pkg::*;

    typedef enum logic [2:0] {
        PH_CMD, PH_OP1, PH_OP2, PH_LIT, PH_RUN
    } phase_t;

    phase_t             phase_reg, phase_next;
    cmd_t               cmd_reg, cmd_next;
    logic [4:0]         len_reg, len_next;
    logic [7:0]         op1_reg, op1_next;
    logic [7:0]         op2_reg, op2_next;
    logic [5:0]         lit_left_reg, lit_left_next;
    logic [15:0]        count_reg, count_next;
    logic [HIST_AW-1:0] hist_pos_reg, hist_pos_next;
    logic [HISTORY_DEPTH-1:0] hvalid_reg, hvalid_next;
    logic [4:0]         idx_reg, idx_next;
    logic               more_reg, more_next;
    logic               pend_reg, pend_next;
    logic               fwd_reg, fwd_next;
    logic [7:0]         fwd_data_reg, fwd_data_next;
    logic               hv_q_reg, hv_q_next;
    logic               head_oob_reg, head_oob_next;

    logic               in_fire;
    logic               copy_cmd;
    logic               dir_emit;
    logic               cp_emit;
    logic               issue;
    logic [7:0]         dir_byte;
    logic [7:0]         cp_byte;
    logic [HIST_AW-1:0] hist_raddr;
    logic [POS_W-1:0]   head_pos;
    logic               head_in_range;
    logic               count_in_head;
    logic [15:0]        count_inc;
    logic               wr_en;
    logic [7:0]         wr_byte;

    assign in_ready = out_free && (phase_reg != PH_RUN);
    assign in_fire  = in_valid && in_ready;
    assign copy_cmd = (cmd_reg == CMD_ABS) || (cmd_reg == CMD_ABS2) || (cmd_reg == CMD_REL);

    // Run issue and emit conditions
    assign dir_emit = (phase_reg == PH_RUN) && !copy_cmd && out_free;
    assign cp_emit  = (phase_reg == PH_RUN) && copy_cmd && pend_reg && out_free;
    assign issue    = (phase_reg == PH_RUN) && copy_cmd && more_reg && (!pend_reg || cp_emit);

    // Pattern bytes for repeat, alternate and count-up runs
    always_comb begin
        unique case (cmd_reg)
            CMD_REP: dir_byte = op1_reg;
            CMD_ALT: dir_byte = idx_reg[0] ? op2_reg : op1_reg;
            CMD_INC: dir_byte = op1_reg + {3'b000, idx_reg};
            default: dir_byte = 8'h00;
        endcase
    end

    // Copy byte: forwarded write, else RAM data with valid/range masking
    always_comb begin
        if (fwd_reg) begin
            cp_byte = fwd_data_reg;
        end else if (cmd_reg == CMD_REL) begin
            cp_byte = hv_q_reg ? hist_rdata : 8'h00;
        end else begin
            cp_byte = head_oob_reg ? 8'h00 : head_rdata;
        end
    end

    // Read addresses; history position accounts for a write in this cycle
    assign hist_raddr    = hist_pos_reg + {{(HIST_AW-1){1'b0}}, cp_emit} - op1_reg[HIST_AW-1:0];
    assign head_pos      = {{(POS_W-8){1'b0}}, op1_reg} + {{(POS_W-5){1'b0}}, idx_reg};
    assign head_in_range = (32'(head_pos) < 32'(HEAD_DEPTH));
    assign count_in_head = (32'(count_reg) < 32'(HEAD_DEPTH));
    assign count_inc     = (count_reg == COUNT_MAX) ? count_reg : count_reg + 16'd1;

    // Next-state logic
    always_comb begin
        phase_next    = phase_reg;
        cmd_next      = cmd_reg;
        len_next      = len_reg;
        op1_next      = op1_reg;
        op2_next      = op2_reg;
        lit_left_next = lit_left_reg;
        count_next    = count_reg;
        hist_pos_next = hist_pos_reg;
        hvalid_next   = hvalid_reg;
        idx_next      = idx_reg;
        more_next     = more_reg;
        pend_next     = pend_reg;
        fwd_next      = fwd_reg;
        fwd_data_next = fwd_data_reg;
        hv_q_next     = hv_q_reg;
        head_oob_next = head_oob_reg;
        beat          = '0;
        wr_en         = 1'b0;
        wr_byte       = 8'h00;

        // input byte handling
        if (in_fire) begin
            unique case (phase_reg)
                PH_CMD: begin
                    if (in_byte == END_BYTE) begin
                        beat.valid = 1'b1;
                        beat.last  = 1'b1;
                        beat.done  = 1'b1;
                        beat.total = count_reg;
                        count_next = 16'd0;
                    end else begin
                        cmd_next = cmd_t'(in_byte[7:5]);
                        len_next = in_byte[4:0];
                        if (cmd_t'(in_byte[7:5]) == CMD_BAD) begin
                            beat.valid = 1'b1;
                            beat.last  = 1'b1;
                            beat.bad   = 1'b1;
                            beat.total = count_reg;
                        end else if (cmd_t'(in_byte[7:5]) == CMD_LIT) begin
                            lit_left_next = {1'b0, in_byte[4:0]} + 6'd1;
                            phase_next    = PH_LIT;
                        end else begin
                            phase_next = PH_OP1;
                        end
                    end
                end
                PH_OP1: begin
                    op1_next = in_byte;
                    if (cmd_reg == CMD_ALT) begin
                        phase_next = PH_OP2;
                    end else begin
                        phase_next = PH_RUN;
                        idx_next   = 5'd0;
                        more_next  = 1'b1;
                        pend_next  = 1'b0;
                        fwd_next   = 1'b0;
                    end
                end
                PH_OP2: begin
                    op2_next   = in_byte;
                    phase_next = PH_RUN;
                    idx_next   = 5'd0;
                    more_next  = 1'b1;
                    pend_next  = 1'b0;
                    fwd_next   = 1'b0;
                end
                PH_LIT: begin
                    wr_en         = 1'b1;
                    wr_byte       = in_byte;
                    beat.last     = 1'b1;
                    lit_left_next = lit_left_reg - 6'd1;
                    if (lit_left_reg == 6'd1) begin
                        phase_next = PH_CMD;
                    end
                end
                default: ;
            endcase
        end

        // pattern runs: one byte per free output cycle
        if (dir_emit) begin
            wr_en     = 1'b1;
            wr_byte   = dir_byte;
            beat.last = (idx_reg == len_reg);
            if (idx_reg == len_reg) begin
                phase_next = PH_CMD;
            end else begin
                idx_next = idx_reg + 5'd1;
            end
        end

        // copy runs: emit the pending read
        if (cp_emit) begin
            wr_en     = 1'b1;
            wr_byte   = cp_byte;
            beat.last = !more_reg;
            pend_next = 1'b0;
            if (!more_reg) begin
                phase_next = PH_CMD;
            end
        end

        // copy runs: issue the next read, forward a same-entry write
        if (issue) begin
            pend_next     = 1'b1;
            hv_q_next     = hvalid_reg[hist_raddr];
            head_oob_next = !head_in_range;
            fwd_data_next = cp_byte;
            if (cmd_reg == CMD_REL) begin
                fwd_next = cp_emit && (hist_raddr == hist_pos_reg);
            end else begin
                fwd_next = cp_emit && head_in_range && count_in_head &&
                           ({7'd0, head_pos} == count_reg);
            end
            if (idx_reg == len_reg) begin
                more_next = 1'b0;
            end else begin
                idx_next = idx_reg + 5'd1;
            end
        end

        // common bookkeeping for every decoded byte
        if (wr_en) begin
            beat.valid                = 1'b1;
            beat.data                 = wr_byte;
            beat.total                = count_inc;
            count_next                = count_inc;
            hist_pos_next             = hist_pos_reg + {{(HIST_AW-1){1'b0}}, 1'b1};
            hvalid_next[hist_pos_reg] = 1'b1;
        end
    end

    // Memory requests
    always_comb begin
        mreq.hist_we    = wr_en;
        mreq.hist_waddr = hist_pos_reg;
        mreq.hist_re    = issue;
        mreq.hist_raddr = hist_raddr;
        mreq.head_we    = wr_en && count_in_head;
        mreq.head_waddr = count_reg[HEAD_AW-1:0];
        mreq.head_re    = issue;
        mreq.head_raddr = head_pos[HEAD_AW-1:0];
        mreq.wdata      = wr_byte;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_CMD;
            cmd_reg      <= CMD_LIT;
            len_reg      <= 5'd0;
            op1_reg      <= 8'd0;
            op2_reg      <= 8'd0;
            lit_left_reg <= 6'd0;
            count_reg    <= 16'd0;
            hist_pos_reg <= '0;
            hvalid_reg   <= '0;
            idx_reg      <= 5'd0;
            more_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            fwd_reg      <= 1'b0;
            fwd_data_reg <= 8'd0;
            hv_q_reg     <= 1'b0;
            head_oob_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            cmd_reg      <= cmd_next;
            len_reg      <= len_next;
            op1_reg      <= op1_next;
            op2_reg      <= op2_next;
            lit_left_reg <= lit_left_next;
            count_reg    <= count_next;
            hist_pos_reg <= hist_pos_next;
            hvalid_reg   <= hvalid_next;
            idx_reg      <= idx_next;
            more_reg     <= more_next;
            pend_reg     <= pend_next;
            fwd_reg      <= fwd_next;
            fwd_data_reg <= fwd_data_next;
            hv_q_reg     <= hv_q_next;
            head_oob_reg <= head_oob_next;
        end
    end

endmodule
